@@ hw/rtl/stt_pkg.sv @@
// Shared types, token codes and keyword table for the script token scanner.
`timescale 1ns / 1ps

package stt_pkg;

   localparam int MAX_KEYWORD_LEN = 9;
   localparam int OFFSET_BITS     = 32;
   localparam int LENGTH_BITS     = 8;
   localparam int KW_LEN_BITS     = $clog2(MAX_KEYWORD_LEN + 1);
   localparam int NUM_WORDS       = 14;
   localparam int MAX_TOKS        = 3;

   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;
   localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
   localparam logic [15:0] COL_MAX  = 16'hFFFF;

   // token kinds
   localparam logic [5:0] K_EOF      = 6'd0;
   localparam logic [5:0] K_UNKNOWN  = 6'd1;
   localparam logic [5:0] K_IDENT    = 6'd2;
   localparam logic [5:0] K_INT      = 6'd3;
   localparam logic [5:0] K_FLOAT    = 6'd4;
   localparam logic [5:0] K_BOOL     = 6'd5;
   localparam logic [5:0] K_NIL      = 6'd6;
   localparam logic [5:0] K_NATIVE   = 6'd7;
   localparam logic [5:0] K_FUNCTION = 6'd8;
   localparam logic [5:0] K_FUNCS    = 6'd9;
   localparam logic [5:0] K_RETURN   = 6'd10;
   localparam logic [5:0] K_INIT     = 6'd11;
   localparam logic [5:0] K_MAIN     = 6'd12;
   localparam logic [5:0] K_LOCAL    = 6'd13;
   localparam logic [5:0] K_WHILE    = 6'd14;
   localparam logic [5:0] K_IF       = 6'd15;
   localparam logic [5:0] K_ELIF     = 6'd16;
   localparam logic [5:0] K_ELSE     = 6'd17;
   localparam logic [5:0] K_PLUS     = 6'd18;
   localparam logic [5:0] K_MINUS    = 6'd19;
   localparam logic [5:0] K_STAR     = 6'd20;
   localparam logic [5:0] K_SLASH    = 6'd21;
   localparam logic [5:0] K_PERCENT  = 6'd22;
   localparam logic [5:0] K_ASSIGN   = 6'd23;
   localparam logic [5:0] K_EQ       = 6'd24;
   localparam logic [5:0] K_NOT      = 6'd25;
   localparam logic [5:0] K_NE       = 6'd26;
   localparam logic [5:0] K_GT       = 6'd27;
   localparam logic [5:0] K_GE       = 6'd28;
   localparam logic [5:0] K_LT       = 6'd29;
   localparam logic [5:0] K_LE       = 6'd30;
   localparam logic [5:0] K_AND      = 6'd31;
   localparam logic [5:0] K_OR       = 6'd32;
   localparam logic [5:0] K_LPAREN   = 6'd33;
   localparam logic [5:0] K_RPAREN   = 6'd34;
   localparam logic [5:0] K_LBRACE   = 6'd35;
   localparam logic [5:0] K_RBRACE   = 6'd36;
   localparam logic [5:0] K_COMMA    = 6'd37;
   localparam logic [5:0] K_SEMI     = 6'd38;

   typedef enum logic [2:0] {
      M_IDLE, M_MINUS, M_COMMENT, M_NUMBER, M_NUMDOT, M_FLOAT, M_IDENT, M_OP
   } mode_type;

   typedef struct packed {
      mode_type                               mode;
      logic [7:0]                             pending;
      logic [OFFSET_BITS-1:0]                 byte_off;
      logic [OFFSET_BITS-1:0]                 tok_start;
      logic [OFFSET_BITS-1:0]                 dot_off;
      logic [23:0]                            cur_line;
      logic [23:0]                            tok_line;
      logic [15:0]                            cur_col;
      logic [15:0]                            tok_col;
      logic [15:0]                            dot_col;
      logic [LENGTH_BITS-1:0]                 run_len;
      logic [MAX_KEYWORD_LEN-1:0][7:0]        prefix;
      logic [31:0]                            mag;
      logic                                   neg;
      logic                                   ovf_flag;
   } lex_state_type;

   localparam lex_state_type STATE_RESET = '{
      mode: M_IDLE, pending: '0, byte_off: '0, tok_start: '0, dot_off: '0,
      cur_line: 24'd1, tok_line: 24'd1, cur_col: 16'd1, tok_col: 16'd1,
      dot_col: 16'd1, run_len: '0, prefix: '0, mag: '0, neg: 1'b0,
      ovf_flag: 1'b0};

   typedef struct packed {
      logic [5:0]  kind;
      logic [31:0] offset;
      logic [7:0]  length;
      logic [23:0] line;
      logic [15:0] column;
      logic [31:0] ival;
      logic        bval;
      logic        ovf;
   } tok_type;

   typedef tok_type [MAX_TOKS-1:0] tok_vec_type;

   typedef struct packed {
      tok_type tok;
      logic    last;
   } out_tok_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] count;
   } push_type;

   // keyword text is right-aligned: byte i of a word sits at byte (len-1-i)
   typedef struct packed {
      logic [MAX_KEYWORD_LEN*8-1:0] text;
      logic [KW_LEN_BITS-1:0]       len;
      logic [5:0]                   kind;
      logic                         bval;
   } word_type;

   localparam word_type WORD_TABLE [NUM_WORDS] = '{
      '{text: "native",    len: KW_LEN_BITS'(6), kind: K_NATIVE,   bval: 1'b0},
      '{text: "function",  len: KW_LEN_BITS'(8), kind: K_FUNCTION, bval: 1'b0},
      '{text: "functions", len: KW_LEN_BITS'(9), kind: K_FUNCS,    bval: 1'b0},
      '{text: "return",    len: KW_LEN_BITS'(6), kind: K_RETURN,   bval: 1'b0},
      '{text: "init",      len: KW_LEN_BITS'(4), kind: K_INIT,     bval: 1'b0},
      '{text: "main",      len: KW_LEN_BITS'(4), kind: K_MAIN,     bval: 1'b0},
      '{text: "local",     len: KW_LEN_BITS'(5), kind: K_LOCAL,    bval: 1'b0},
      '{text: "while",     len: KW_LEN_BITS'(5), kind: K_WHILE,    bval: 1'b0},
      '{text: "if",        len: KW_LEN_BITS'(2), kind: K_IF,       bval: 1'b0},
      '{text: "elif",      len: KW_LEN_BITS'(4), kind: K_ELIF,     bval: 1'b0},
      '{text: "else",      len: KW_LEN_BITS'(4), kind: K_ELSE,     bval: 1'b0},
      '{text: "true",      len: KW_LEN_BITS'(4), kind: K_BOOL,     bval: 1'b1},
      '{text: "false",     len: KW_LEN_BITS'(5), kind: K_BOOL,     bval: 1'b0},
      '{text: "nil",       len: KW_LEN_BITS'(3), kind: K_NIL,      bval: 1'b0}
   };

endpackage

@@ hw/rtl/stt_lexer.sv @@
// Scanner state registers and the per-byte next-state and token logic.
`timescale 1ns / 1ps

module stt_lexer (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_byte,
   input  logic                end_of_text,
   output stt_pkg::push_type   push,
   output stt_pkg::tok_vec_type toks
);
   import stt_pkg::*;

   lex_state_type st_ff, st_in;
   tok_vec_type   res;
   logic [1:0]    n;

   function automatic tok_type mk_tok(logic [5:0] kind, logic [OFFSET_BITS-1:0] off,
                                      logic [LENGTH_BITS-1:0] len, logic [23:0] line,
                                      logic [15:0] col, logic [31:0] ival, logic bval,
                                      logic ovf);
      tok_type t;
      t.kind   = kind;
      t.offset = 32'(off);
      t.length = 8'(len);
      t.line   = line;
      t.column = col;
      t.ival   = ival;
      t.bval   = bval;
      t.ovf    = ovf;
      return t;
   endfunction

   function automatic tok_type simple_tok(lex_state_type s, logic [5:0] kind,
                                          logic [LENGTH_BITS-1:0] len);
      return mk_tok(kind, s.tok_start, len, s.tok_line, s.tok_col, '0, 1'b0, 1'b0);
   endfunction

   function automatic tok_type int_tok(lex_state_type s);
      logic        o;
      logic [31:0] v;
      o = s.ovf_flag || (!s.neg && s.mag > 32'h7FFF_FFFF);
      v = o ? '0 : (s.neg ? (32'd0 - s.mag) : s.mag);
      return mk_tok(K_INT, s.tok_start, s.run_len, s.tok_line, s.tok_col, v, 1'b0, o);
   endfunction

   function automatic tok_type word_tok(lex_state_type s);
      tok_type t;
      logic    hit;
      logic    match;
      int      k;
      int      i;
      t   = simple_tok(s, K_IDENT, s.run_len);
      hit = 1'b0;
      for (k = 0; k < NUM_WORDS; k++) begin
         match = (32'(s.run_len) == 32'(WORD_TABLE[k].len));
         for (i = 0; i < MAX_KEYWORD_LEN; i++) begin
            if (i < int'(WORD_TABLE[k].len) &&
                s.prefix[i] != WORD_TABLE[k].text[8*(int'(WORD_TABLE[k].len)-1-i) +: 8])
               match = 1'b0;
         end
         if (match && !hit) begin
            hit = 1'b1;
            t   = mk_tok(WORD_TABLE[k].kind, s.tok_start, s.run_len, s.tok_line,
                         s.tok_col, '0, WORD_TABLE[k].bval, 1'b0);
         end
      end
      return t;
   endfunction

   function automatic logic [LENGTH_BITS-1:0] len_inc(logic [LENGTH_BITS-1:0] v,
                                                      logic [1:0] by);
      logic [LENGTH_BITS:0] r;
      r = {1'b0, v} + (LENGTH_BITS+1)'(by);
      return (r > {1'b0, LENGTH_MAX}) ? LENGTH_MAX : r[LENGTH_BITS-1:0];
   endfunction

   function automatic void push_tok(inout tok_vec_type r, inout logic [1:0] cnt,
                                    input tok_type t);
      r[cnt] = t;
      cnt    = cnt + 2'd1;
   endfunction

   function automatic void digit_in(inout lex_state_type s, input logic [7:0] c);
      logic [35:0] nxt;
      if (!s.ovf_flag) begin
         nxt = ({4'b0, s.mag} << 3) + ({4'b0, s.mag} << 1) + {32'b0, c[3:0]};
         if (nxt > 36'd2147483648) s.ovf_flag = 1'b1;
         else s.mag = nxt[31:0];
      end
   endfunction

   function automatic void begin_tok(inout lex_state_type s, input mode_type m);
      s.mode      = m;
      s.tok_start = s.byte_off;
      s.tok_line  = s.cur_line;
      s.tok_col   = s.cur_col;
      s.run_len   = LENGTH_BITS'(1);
   endfunction

   function automatic void flush(inout lex_state_type s, inout tok_vec_type r,
                                 inout logic [1:0] cnt);
      logic [5:0] k;
      case (s.mode)
         M_MINUS:  push_tok(r, cnt, simple_tok(s, K_MINUS, LENGTH_BITS'(1)));
         M_NUMBER: push_tok(r, cnt, int_tok(s));
         M_NUMDOT: begin
            push_tok(r, cnt, int_tok(s));
            push_tok(r, cnt, mk_tok(K_UNKNOWN, s.dot_off, LENGTH_BITS'(1), s.tok_line,
                                    s.dot_col, '0, 1'b0, 1'b0));
         end
         M_FLOAT:  push_tok(r, cnt, simple_tok(s, K_FLOAT, s.run_len));
         M_IDENT:  push_tok(r, cnt, word_tok(s));
         M_OP: begin
            case (s.pending)
               "!":     k = K_NOT;
               "=":     k = K_ASSIGN;
               ">":     k = K_GT;
               "<":     k = K_LT;
               default: k = K_UNKNOWN;
            endcase
            push_tok(r, cnt, simple_tok(s, k, LENGTH_BITS'(1)));
         end
         default: ;
      endcase
      s.mode = M_IDLE;
   endfunction

   function automatic void idle_char(inout lex_state_type s, input logic [7:0] c,
                                     inout tok_vec_type r, inout logic [1:0] cnt);
      logic [5:0] k;
      s.mode = M_IDLE;
      if (c inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
      end else if (c == "-") begin
         begin_tok(s, M_MINUS);
      end else if (c inside {["0":"9"]}) begin
         begin_tok(s, M_NUMBER);
         s.mag      = '0;
         s.neg      = 1'b0;
         s.ovf_flag = 1'b0;
         digit_in(s, c);
      end else if (c inside {["a":"z"], ["A":"Z"], "_"}) begin
         begin_tok(s, M_IDENT);
         s.prefix[0] = c;
      end else if (c inside {"!", "=", ">", "<", "&", "|"}) begin
         begin_tok(s, M_OP);
         s.pending = c;
      end else begin
         begin_tok(s, M_IDLE);
         case (c)
            "+":     k = K_PLUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "%":     k = K_PERCENT;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            default: k = K_UNKNOWN;
         endcase
         push_tok(r, cnt, simple_tok(s, k, LENGTH_BITS'(1)));
      end
   endfunction

   always_comb begin
      logic       is_digit;
      logic       is_word;
      logic [5:0] k;
      int         i;
      st_in    = st_ff;
      res      = '0;
      n        = 2'd0;
      k        = K_EOF;
      is_digit = char_byte inside {["0":"9"]};
      is_word  = is_digit || (char_byte inside {["a":"z"], ["A":"Z"], "_"});
      if (end_of_text) begin
         flush(st_in, res, n);
         push_tok(res, n, mk_tok(K_EOF, st_ff.byte_off, '0, st_ff.cur_line,
                                 st_ff.cur_col, '0, 1'b0, 1'b0));
         st_in        = STATE_RESET;
         st_in.prefix = st_ff.prefix;
      end else begin
         case (st_ff.mode)
            M_MINUS: begin
               if (char_byte == "-") begin
                  st_in.mode = M_COMMENT;
               end else if (is_digit) begin
                  st_in.mode     = M_NUMBER;
                  st_in.mag      = '0;
                  st_in.neg      = 1'b1;
                  st_in.ovf_flag = 1'b0;
                  digit_in(st_in, char_byte);
                  st_in.run_len  = len_inc(st_in.run_len, 2'd1);
               end else begin
                  flush(st_in, res, n);
                  idle_char(st_in, char_byte, res, n);
               end
            end
            M_COMMENT: begin
               if (char_byte == 8'h0A) st_in.mode = M_IDLE;
            end
            M_NUMBER: begin
               if (is_digit) begin
                  digit_in(st_in, char_byte);
                  st_in.run_len = len_inc(st_in.run_len, 2'd1);
               end else if (char_byte == ".") begin
                  st_in.mode    = M_NUMDOT;
                  st_in.dot_off = st_ff.byte_off;
                  st_in.dot_col = st_ff.cur_col;
               end else begin
                  flush(st_in, res, n);
                  idle_char(st_in, char_byte, res, n);
               end
            end
            M_NUMDOT: begin
               if (is_digit) begin
                  st_in.mode    = M_FLOAT;
                  st_in.run_len = len_inc(st_in.run_len, 2'd2);
               end else begin
                  flush(st_in, res, n);
                  idle_char(st_in, char_byte, res, n);
               end
            end
            M_FLOAT: begin
               if (is_digit) begin
                  st_in.run_len = len_inc(st_in.run_len, 2'd1);
               end else begin
                  flush(st_in, res, n);
                  idle_char(st_in, char_byte, res, n);
               end
            end
            M_IDENT: begin
               if (is_word) begin
                  for (i = 0; i < MAX_KEYWORD_LEN; i++) begin
                     if (32'(st_ff.run_len) == 32'(i)) st_in.prefix[i] = char_byte;
                  end
                  st_in.run_len = len_inc(st_in.run_len, 2'd1);
               end else begin
                  flush(st_in, res, n);
                  idle_char(st_in, char_byte, res, n);
               end
            end
            M_OP: begin
               if (char_byte == "=") begin
                  case (st_ff.pending)
                     "!":     k = K_NE;
                     "=":     k = K_EQ;
                     ">":     k = K_GE;
                     "<":     k = K_LE;
                     default: k = K_EOF;
                  endcase
               end
               if (char_byte == "&" && st_ff.pending == "&") k = K_AND;
               if (char_byte == "|" && st_ff.pending == "|") k = K_OR;
               if (k != K_EOF) begin
                  push_tok(res, n, simple_tok(st_ff, k, LENGTH_BITS'(2)));
                  st_in.mode = M_IDLE;
               end else begin
                  flush(st_in, res, n);
                  idle_char(st_in, char_byte, res, n);
               end
            end
            default: idle_char(st_in, char_byte, res, n);
         endcase
         st_in.byte_off = st_ff.byte_off + OFFSET_BITS'(1);
         if (char_byte == 8'h0A) begin
            if (st_ff.cur_line < LINE_MAX) st_in.cur_line = st_ff.cur_line + 24'd1;
            st_in.cur_col = 16'd1;
         end else if (st_ff.cur_col < COL_MAX) begin
            st_in.cur_col = st_ff.cur_col + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= STATE_RESET;
      else if (accept) st_ff <= st_in;
   end

   assign push.valid = accept && (n != 2'd0);
   assign push.count = n;
   assign toks       = res;

endmodule

@@ hw/rtl/stt_outbuf.sv @@
// Three-entry result buffer that drains the tokens of one byte in order.
`timescale 1ns / 1ps

module stt_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  stt_pkg::push_type    push,
   input  stt_pkg::tok_vec_type toks,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output stt_pkg::out_tok_type head,
   output logic                 can_accept
);
   import stt_pkg::*;

   out_tok_type [MAX_TOKS-1:0] q_ff, q_in;
   logic [1:0]                 cnt_ff, cnt_in;
   logic                       pop;

   assign rsp_valid  = cnt_ff != 2'd0;
   assign head       = q_ff[0];
   assign pop        = rsp_valid && !rsp_stall;
   // new byte only when the buffer is empty or empties this cycle
   assign can_accept = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   always_comb begin
      int i;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         for (i = 0; i < MAX_TOKS - 1; i++) q_in[i] = q_ff[i+1];
         cnt_in = cnt_ff - 2'd1;
      end
      if (push.valid) begin
         for (i = 0; i < MAX_TOKS; i++) begin
            q_in[i].tok  = toks[i];
            q_in[i].last = (2'(i) == push.count - 2'd1);
         end
         cnt_in = push.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

@@ hw/rtl/script_token_scanner.sv @@
// Top level of the streaming script token scanner.
// Usage:
//   Request channel (req_*): one source byte per transaction, or an
//   end-of-text marker that flushes the pending token and yields Eof.
//   Response channel (rsp_*): one token per transaction with kind, start
//   offset, length, line, column and literal values; rsp_last_result marks
//   the last token caused by one request.
// A token appears at the response port in the cycle after the byte that completes it.
// Throughput: one byte per cycle while each byte yields at most one token and
//   the receiver does not stall; a byte that yields more tokens holds the next
//   byte off while the three-entry response buffer drains one token per cycle.
// Reset clears the scanner to the start of a text (offset 0, line 1,
//   column 1) and empties the response buffer. An end-of-text request
//   clears the scanner in the same way after emitting Eof.
// When the receiver stalls, the current token holds steady and req_stall
//   rises as soon as the buffered tokens are not all taken.
`timescale 1ns / 1ps

module script_token_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [31:0] rsp_start_offset,
   output logic [7:0]  rsp_token_length,
   output logic [23:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic signed [31:0] rsp_int_value,
   output logic        rsp_bool_value,
   output logic        rsp_int_overflow,
   output logic        rsp_last_result
);
   import stt_pkg::*;

   push_type    push;
   tok_vec_type toks;
   out_tok_type head;
   logic        can_accept;
   logic        accept;

   assign req_stall = !can_accept;
   assign accept    = req_valid && can_accept;

   stt_lexer u_lexer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_byte   (req_char_byte),
      .end_of_text (req_end_of_text),
      .push        (push),
      .toks        (toks)
   );

   stt_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .toks       (toks),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .head       (head),
      .can_accept (can_accept)
   );

   assign rsp_token_kind    = head.tok.kind;
   assign rsp_start_offset  = head.tok.offset;
   assign rsp_token_length  = head.tok.length;
   assign rsp_line_number   = head.tok.line;
   assign rsp_column_number = head.tok.column;
   assign rsp_int_value     = head.tok.ival;
   assign rsp_bool_value    = head.tok.bval;
   assign rsp_int_overflow  = head.tok.ovf;
   assign rsp_last_result   = head.last;

endmodule

@@ hw/rtl/stt_checker.sv @@
// Port-level checks for the script token scanner, bound to the top level.
`timescale 1ns / 1ps

module stt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_token_kind,
   input logic signed [31:0] rsp_int_value,
   input logic        rsp_bool_value,
   input logic        rsp_int_overflow,
   input logic        rsp_last_result
);
   import stt_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind))
      else $error("stalled token changed");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == K_EOF |-> rsp_last_result)
      else $error("Eof not last of its transaction");

   a_int_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != K_INT |-> rsp_int_value == 0 && !rsp_int_overflow)
      else $error("integer fields set on non-integer token");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_int_overflow |-> rsp_int_value == 0 && !rsp_bool_value)
      else $error("overflowed integer carries a value");

endmodule

bind script_token_scanner stt_checker u_stt_checker (.*);

@@ tb/script_token_scanner_tb.sv @@
// Self-checking testbench for the script token scanner: directed texts and random texts.
`timescale 1ns / 1ps

module script_token_scanner_tb;
   import stt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_byte = '0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [31:0] rsp_start_offset;
   logic [7:0]  rsp_token_length;
   logic [23:0] rsp_line_number;
   logic [15:0] rsp_column_number;
   logic signed [31:0] rsp_int_value;
   logic        rsp_bool_value;
   logic        rsp_int_overflow;
   logic        rsp_last_result;

   script_token_scanner u_top (.*);

   always #4 clock = ~clock;

   out_tok_type expected_tokens[$];
   int  error_count = 0;
   int  bytes_sent = 0;
   int  texts_sent = 0;
   int  tokens_seen = 0;
   bit  idling_on = 1'b1;

   // shadow copy of the scanner state
   mode_type    sh_mode;
   logic [7:0]  sh_pend;
   logic [31:0] sh_off, sh_tstart, sh_dotoff;
   logic [23:0] sh_line, sh_tline;
   logic [15:0] sh_col, sh_tcol, sh_dotcol;
   int          sh_run;
   logic [7:0]  sh_word[MAX_KEYWORD_LEN];
   logic [31:0] sh_mag;
   bit          sh_neg, sh_ovf;
   int          step_tokens;

   function automatic void scanner_clear();
      sh_mode = M_IDLE; sh_pend = '0; sh_off = '0; sh_tstart = '0; sh_dotoff = '0;
      sh_line = 24'd1; sh_tline = 24'd1; sh_col = 16'd1; sh_tcol = 16'd1;
      sh_dotcol = 16'd1; sh_run = 0; sh_mag = '0; sh_neg = 0; sh_ovf = 0;
   endfunction

   function automatic void push_token(logic [5:0] k, logic [31:0] off, int len,
                                      logic [23:0] ln, logic [15:0] col,
                                      logic [31:0] iv, bit bv, bit ov);
      out_tok_type t;
      if (step_tokens >= MAX_TOKS) return;
      t.tok.kind = k; t.tok.offset = off; t.tok.length = (len > 255) ? 8'd255 : len[7:0];
      t.tok.line = ln; t.tok.column = col; t.tok.ival = iv; t.tok.bval = bv;
      t.tok.ovf = ov; t.last = 1'b0;
      expected_tokens.push_back(t);
      step_tokens++;
   endfunction

   function automatic void push_plain(logic [5:0] k, int len);
      push_token(k, sh_tstart, len, sh_tline, sh_tcol, '0, 0, 0);
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic int grow(int n, int by);
      return (n + by > 255) ? 255 : n + by;
   endfunction

   function automatic void push_int();
      bit ov;
      logic [31:0] v;
      ov = sh_ovf || (!sh_neg && sh_mag > 32'h7FFF_FFFF);
      v = ov ? '0 : (sh_neg ? -sh_mag : sh_mag);
      push_token(K_INT, sh_tstart, sh_run, sh_tline, sh_tcol, v, 0, ov);
   endfunction

   function automatic void push_word();
      string w;
      logic [5:0] k;
      bit bv;
      w = ""; k = K_IDENT; bv = 0;
      if (sh_run <= MAX_KEYWORD_LEN) begin
         for (int i = 0; i < sh_run; i++) w = $sformatf("%s%c", w, sh_word[i]);
         case (w)
            "native":    k = K_NATIVE;
            "function":  k = K_FUNCTION;
            "functions": k = K_FUNCS;
            "return":    k = K_RETURN;
            "init":      k = K_INIT;
            "main":      k = K_MAIN;
            "local":     k = K_LOCAL;
            "while":     k = K_WHILE;
            "if":        k = K_IF;
            "elif":      k = K_ELIF;
            "else":      k = K_ELSE;
            "true":      begin k = K_BOOL; bv = 1; end
            "false":     k = K_BOOL;
            "nil":       k = K_NIL;
            default:     k = K_IDENT;
         endcase
      end
      push_token(k, sh_tstart, sh_run, sh_tline, sh_tcol, '0, bv, 0);
   endfunction

   function automatic void add_digit(logic [7:0] c);
      logic [63:0] nxt;
      if (sh_ovf) return;
      nxt = 64'(sh_mag) * 10 + 64'(c - "0");
      if (nxt > 64'd2147483648) sh_ovf = 1;
      else sh_mag = nxt[31:0];
   endfunction

   function automatic void open_token(mode_type m);
      sh_mode = m; sh_tstart = sh_off; sh_tline = sh_line; sh_tcol = sh_col; sh_run = 1;
   endfunction

   function automatic void flush_token();
      case (sh_mode)
         M_MINUS:  push_plain(K_MINUS, 1);
         M_NUMBER: push_int();
         M_NUMDOT: begin
            push_int();
            push_token(K_UNKNOWN, sh_dotoff, 1, sh_tline, sh_dotcol, '0, 0, 0);
         end
         M_FLOAT:  push_plain(K_FLOAT, sh_run);
         M_IDENT:  push_word();
         M_OP: begin
            case (sh_pend)
               "!":     push_plain(K_NOT, 1);
               "=":     push_plain(K_ASSIGN, 1);
               ">":     push_plain(K_GT, 1);
               "<":     push_plain(K_LT, 1);
               default: push_plain(K_UNKNOWN, 1);
            endcase
         end
         default: ;
      endcase
      sh_mode = M_IDLE;
   endfunction

   function automatic void start_from_idle(logic [7:0] c);
      logic [5:0] k;
      sh_mode = M_IDLE;
      if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) return;
      if (c == "-") begin open_token(M_MINUS); return; end
      if (is_digit(c)) begin
         open_token(M_NUMBER);
         sh_mag = '0; sh_neg = 0; sh_ovf = 0;
         add_digit(c);
         return;
      end
      if (is_alpha(c)) begin open_token(M_IDENT); sh_word[0] = c; return; end
      if (c == "!" || c == "=" || c == ">" || c == "<" || c == "&" || c == "|") begin
         open_token(M_OP); sh_pend = c; return;
      end
      open_token(M_IDLE);
      case (c)
         "+": k = K_PLUS;    "*": k = K_STAR;    "/": k = K_SLASH;
         "%": k = K_PERCENT; "(": k = K_LPAREN;  ")": k = K_RPAREN;
         "{": k = K_LBRACE;  "}": k = K_RBRACE;  ",": k = K_COMMA;
         ";": k = K_SEMI;    default: k = K_UNKNOWN;
      endcase
      push_plain(k, 1);
   endfunction

   function automatic void scan_byte(logic [7:0] c);
      logic [5:0] k;
      case (sh_mode)
         M_MINUS:
            if (c == "-") sh_mode = M_COMMENT;
            else if (is_digit(c)) begin
               sh_mode = M_NUMBER; sh_mag = '0; sh_neg = 1; sh_ovf = 0;
               add_digit(c); sh_run = grow(sh_run, 1);
            end else begin flush_token(); start_from_idle(c); end
         M_COMMENT: if (c == 8'h0A) sh_mode = M_IDLE;
         M_NUMBER:
            if (is_digit(c)) begin add_digit(c); sh_run = grow(sh_run, 1); end
            else if (c == ".") begin
               sh_mode = M_NUMDOT; sh_dotoff = sh_off; sh_dotcol = sh_col;
            end else begin flush_token(); start_from_idle(c); end
         M_NUMDOT:
            if (is_digit(c)) begin sh_mode = M_FLOAT; sh_run = grow(sh_run, 2); end
            else begin flush_token(); start_from_idle(c); end
         M_FLOAT:
            if (is_digit(c)) sh_run = grow(sh_run, 1);
            else begin flush_token(); start_from_idle(c); end
         M_IDENT:
            if (is_alpha(c) || is_digit(c)) begin
               if (sh_run < MAX_KEYWORD_LEN) sh_word[sh_run] = c;
               sh_run = grow(sh_run, 1);
            end else begin flush_token(); start_from_idle(c); end
         M_OP: begin
            k = K_EOF;
            if (c == "=") case (sh_pend)
               "!": k = K_NE; "=": k = K_EQ; ">": k = K_GE; "<": k = K_LE;
               default: ;
            endcase
            if (c == "&" && sh_pend == "&") k = K_AND;
            if (c == "|" && sh_pend == "|") k = K_OR;
            if (k != K_EOF) begin push_plain(k, 2); sh_mode = M_IDLE; end
            else begin flush_token(); start_from_idle(c); end
         end
         default: start_from_idle(c);
      endcase
      sh_off = sh_off + 1;
      if (c == 8'h0A) begin
         if (sh_line != LINE_MAX) sh_line = sh_line + 1;
         sh_col = 16'd1;
      end else if (sh_col != COL_MAX) sh_col = sh_col + 1;
   endfunction

   function automatic void predict_transaction(logic [7:0] c, bit eot);
      int first;
      first = expected_tokens.size();
      step_tokens = 0;
      if (eot) begin
         flush_token();
         push_token(K_EOF, sh_off, 0, sh_line, sh_col, '0, 0, 0);
         scanner_clear();
      end else scan_byte(c);
      if (expected_tokens.size() > first) expected_tokens[$].last = 1'b1;
   endfunction

   // drive one request transaction; inputs move on the falling edge
   task automatic send_item(logic [7:0] c, bit eot);
      while (idling_on && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         req_char_byte <= 8'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_byte <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
      predict_transaction(c, eot);
      bytes_sent++;
      if (eot) texts_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   always @(negedge clock)
      if (!reset) rsp_stall <= idling_on && ($urandom_range(99) < 21);

   function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $error("%s mismatch: expected %0h, got %0h", name, e, a);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      out_tok_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         tokens_seen++;
         if (expected_tokens.size() == 0) begin
            $error("token with no expectation: kind %0d", rsp_token_kind);
            error_count++;
         end else begin
            e = expected_tokens.pop_front();
            check_field("token_kind", e.tok.kind, rsp_token_kind);
            check_field("start_offset", e.tok.offset, rsp_start_offset);
            check_field("token_length", e.tok.length, rsp_token_length);
            check_field("line_number", e.tok.line, rsp_line_number);
            check_field("column_number", e.tok.column, rsp_column_number);
            check_field("int_value", e.tok.ival, $unsigned(rsp_int_value));
            check_field("bool_value", e.tok.bval, rsp_bool_value);
            check_field("int_overflow", e.tok.ovf, rsp_int_overflow);
            check_field("last_result", e.last, rsp_last_result);
         end
      end
   end

   task automatic test_operators();
      send_text("+-*/%=(==)!{!=},>;>=<<=&&||&|.\t\r\n");
      send_text("a-1 x - 2 7-3 ) -x --note - here\n-");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h80, 1'b0);
      send_item("Z", 1'b1);
   endtask

   task automatic test_words();
      send_text("functions function if elif ");
      send_text("true nil iff functionsx Foo_9 el");
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_numbers();
      send_text("0 2147483647 2147483648 -2147483648 -2147483649 99999999999 ");
      send_text("1.5 3. .5 12.x 7.25;4");
      send_item(8'h00, 1'b1);
      send_text("9.");
      send_item(8'h00, 1'b1);
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_random_texts();
      string words[15] = '{"native", "function", "functions", "return", "init", "main",
                           "local", "while", "if", "elif", "else", "true", "false", "nil",
                           "abc"};
      string ops[12] = '{"==", "!=", ">=", "<=", "&&", "||", "=", "!", "<", ">", "&", "|"};
      string punct = "+*/%(){},;";
      int goal;
      goal = bytes_sent + 20;
      while (bytes_sent < goal) begin
         // a stretch with no idling on either side
         if (bytes_sent > goal - 18 && bytes_sent < goal - 3) idling_on = 1'b0;
         else idling_on = 1'b1;
         case ($urandom_range(11))
            0, 1: send_text(words[$urandom_range(14)]);
            2: begin
               send_item("a" + 8'($urandom_range(25)), 1'b0);
               repeat ($urandom_range(10)) send_item("0" + 8'($urandom_range(9)), 1'b0);
            end
            3, 4: begin
               if ($urandom_range(1)) send_item("-", 1'b0);
               repeat ($urandom_range(1, 11)) send_item("0" + 8'($urandom_range(9)), 1'b0);
               if ($urandom_range(2) == 0) begin
                  send_item(".", 1'b0);
                  repeat ($urandom_range(2)) send_item("0" + 8'($urandom_range(9)), 1'b0);
               end
            end
            5: send_text(ops[$urandom_range(11)]);
            6: send_item(punct[$urandom_range(9)], 1'b0);
            7: send_text("-- c\n");
            8: send_item(8'($urandom), 1'b0);
            9: send_item(8'($urandom), ($urandom_range(4) == 0));
            default: send_item($urandom_range(1) ? " " : 8'h0A, 1'b0);
         endcase
      end
      idling_on = 1'b1;
      send_item(8'($urandom), 1'b1);
   endtask

   initial begin
      scanner_clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_operators();
      test_words();
      test_numbers();
      test_random_texts();
      req_valid <= 1'b0;
      wait (expected_tokens.size() == 0);
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes in %0d texts; checked %0d tokens, %0d errors.",
               bytes_sent, texts_sent, tokens_seen, error_count);
      if (error_count == 0 && expected_tokens.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule
